// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line drawer RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This macro checks a property at every rising clock edge outside reset.
`define CLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// This macro checks that a condition holds in the cycle after a trigger.
`define CLD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/cld_pkg.sv =====
// Package for the clipped line drawer: payload structs, register indexes and constants.
// It has no dependencies. The walker and the top level import it.
`default_nettype none

package cld_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int REG_W          = 15;
  localparam int PIX_W          = 15;
  localparam int LIMIT_W        = 17;
  localparam int STEP_SLACK     = 8;
  localparam int CFG_IDX_W      = 3;

  localparam logic [REG_W-1:0] CLIP_LEFT_RST     = 15'd0;
  localparam logic [REG_W-1:0] CLIP_TOP_RST      = 15'd0;
  localparam logic [REG_W-1:0] CLIP_WIDTH_RST    = 15'd1024;
  localparam logic [REG_W-1:0] CLIP_HEIGHT_RST   = 15'd768;
  localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = 15'd1024;
  localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = 15'd768;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT     = 3'd0,
    CFG_CLIP_TOP      = 3'd1,
    CFG_CLIP_WIDTH    = 3'd2,
    CFG_CLIP_HEIGHT   = 3'd3,
    CFG_SCREEN_WIDTH  = 3'd4,
    CFG_SCREEN_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic [31:0]        line_color;
  } in_item_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [31:0]      pixel_color;
    logic             line_done;
    logic             line_active;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] clip_left;
    logic [REG_W-1:0] clip_top;
    logic [REG_W-1:0] clip_width;
    logic [REG_W-1:0] clip_height;
    logic [REG_W-1:0] screen_width;
    logic [REG_W-1:0] screen_height;
  } cld_cfg_t;

  typedef struct packed {
    logic busy;
  } cld_status_t;

endpackage

`default_nettype wire

// ===== rtl/clipped_line_drawer.sv =====
// Top level of the clipped line drawer: handshakes, register file and result register.
// Depends on cld_pkg, cld_walker and assert_macros.svh.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      in_item_i  (in_item_t)
// out       output     out_valid_o / out_ready_i    out_item_o (out_item_t)
// cfg       input      cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// Every transaction on the input channel is finished in the cycle it is accepted: the walker
// computes the result and the next walker state from its registers in one pass, and the
// result is held in the output register from the next cycle. One item is taken per cycle
// when not stalled; the input is stalled only while the output register holds a result that the
// downstream side has not taken; a taken result frees the register in the same cycle.
// Reset clears the walker (no line in progress) and loads the default clip window
// and screen size; no clearing pass is needed.

module clipped_line_drawer import cld_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [REG_W-1:0]     cfg_wdata_i
);

`include "assert_macros.svh"

  cld_cfg_t    cfg_q, cfg_d;
  out_item_t   out_q;
  out_item_t   res;
  cld_status_t status;
  logic        out_valid_q, out_valid_d;
  logic        fire;

  // The output register accepts a new result when it is empty or is being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  cld_walker #(
    .CoordBits(CoordBits)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .res_o   (res),
    .status_o(status)
  );

  // Register writes; indexes past the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CLIP_LEFT:     cfg_d.clip_left     = cfg_wdata_i;
        CFG_CLIP_TOP:      cfg_d.clip_top      = cfg_wdata_i;
        CFG_CLIP_WIDTH:    cfg_d.clip_width    = cfg_wdata_i;
        CFG_CLIP_HEIGHT:   cfg_d.clip_height   = cfg_wdata_i;
        CFG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_wdata_i;
        CFG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_left     <= CLIP_LEFT_RST;
      cfg_q.clip_top      <= CLIP_TOP_RST;
      cfg_q.clip_width    <= CLIP_WIDTH_RST;
      cfg_q.clip_height   <= CLIP_HEIGHT_RST;
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Result register: loaded on every accepted transaction, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CLD_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ready_o, "input stalled with empty output")
  `CLD_ASSERT_NEXT(a_start_result, fire && in_item_i.opcode == OP_START,
    out_valid_o && !out_item_o.line_active && !out_item_o.pixel_valid && status.busy,
    "start transaction did not arm the walker with an empty result")
  `CLD_ASSERT_NEXT(a_step_active, fire && in_item_i.opcode == OP_STEP && status.busy,
    out_valid_o && out_item_o.line_active, "step on a busy line lost line_active")
  `CLD_ASSERT(a_pixel_needs_line, out_valid_o && (out_item_o.pixel_valid ||
    out_item_o.line_done) |-> out_item_o.line_active, "pixel or done without an active line")

endmodule

`default_nettype wire

// ===== rtl/cld_walker.sv =====
// Bresenham walker state and its combinational step and clip logic.
// Depends on cld_pkg for the payload structs, the register struct and constants.
`default_nettype none

module cld_walker import cld_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire in_item_t    item_i,
  input  wire cld_cfg_t    cfg_i,
  output out_item_t        res_o,
  output cld_status_t      status_o
);

  localparam int ErrW = CoordBits + 2;
  localparam int E2W  = CoordBits + 3;
  localparam int CmpW = ((CoordBits > 17) ? CoordBits : 17) + 1;
  localparam int NarW = (CoordBits > 16) ? CoordBits : 16;
  localparam int PixW = (CoordBits > PIX_W) ? CoordBits : PIX_W;

  logic signed [CoordBits-1:0] cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic signed [CoordBits-1:0] tgt_x_q, tgt_y_q, tgt_x_d, tgt_y_d;
  logic [CoordBits-1:0]        dx_q, dy_q, dx_d, dy_d;
  logic                        neg_x_q, neg_y_q, neg_x_d, neg_y_d;
  logic signed [ErrW-1:0]      err_q, err_d;
  logic [LIMIT_W-1:0]          steps_q, steps_d;
  logic [31:0]                 color_q, color_d;
  logic                        busy_q, busy_d;

  // Start path: narrowed endpoints, spans and directions.
  logic signed [NarW-1:0]      x1_ext, y1_ext, x2_ext, y2_ext;
  logic signed [CoordBits-1:0] x1, y1, x2, y2;
  logic signed [CoordBits:0]   dxs, dys;
  logic [CoordBits-1:0]        dx_new, dy_new;

  // Step path.
  logic [LIMIT_W-1:0]          limit;
  logic                        at_end, done, in_clip;
  logic signed [E2W-1:0]       e2, dx_e, dy_e, err_e;
  logic                        move_x, move_y;
  logic signed [CmpW-1:0]      cx, cy, left, top, right, bottom;
  logic signed [PixW-1:0]      px_ext, py_ext;

  always_comb begin
    x1_ext = NarW'(item_i.x_start);
    y1_ext = NarW'(item_i.y_start);
    x2_ext = NarW'(item_i.x_end);
    y2_ext = NarW'(item_i.y_end);
    x1 = x1_ext[CoordBits-1:0];
    y1 = y1_ext[CoordBits-1:0];
    x2 = x2_ext[CoordBits-1:0];
    y2 = y2_ext[CoordBits-1:0];
    dxs = (CoordBits+1)'(x2) - (CoordBits+1)'(x1);
    dys = (CoordBits+1)'(y2) - (CoordBits+1)'(y1);
    dx_new = dxs[CoordBits] ? CoordBits'(-dxs) : dxs[CoordBits-1:0];
    dy_new = dys[CoordBits] ? CoordBits'(-dys) : dys[CoordBits-1:0];
  end

  always_comb begin
    limit  = LIMIT_W'(cfg_i.screen_width) + LIMIT_W'(cfg_i.screen_height)
           + LIMIT_W'(STEP_SLACK);
    at_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
    done   = at_end || ((LIMIT_W+1)'(steps_q) + (LIMIT_W+1)'(1) >= (LIMIT_W+1)'(limit));

    e2     = E2W'(err_q) <<< 1;
    dx_e   = signed'(E2W'(dx_q));
    dy_e   = signed'(E2W'(dy_q));
    move_x = e2 > -dy_e;
    move_y = e2 < dx_e;
    err_e  = E2W'(err_q) - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);

    cx     = CmpW'(cur_x_q);
    cy     = CmpW'(cur_y_q);
    left   = signed'(CmpW'(cfg_i.clip_left));
    top    = signed'(CmpW'(cfg_i.clip_top));
    right  = left + signed'(CmpW'(cfg_i.clip_width));
    bottom = top + signed'(CmpW'(cfg_i.clip_height));
    in_clip = (cx >= left) && (cy >= top) && (cx < right) && (cy < bottom);

    px_ext = PixW'(cur_x_q);
    py_ext = PixW'(cur_y_q);
  end

  // Result of the item being accepted; the top level registers it.
  always_comb begin
    res_o = '0;
    if (item_i.opcode == OP_STEP && busy_q) begin
      res_o.line_active = 1'b1;
      res_o.line_done   = done;
      if (in_clip) begin
        res_o.pixel_valid = 1'b1;
        res_o.pixel_x     = px_ext[PIX_W-1:0];
        res_o.pixel_y     = py_ext[PIX_W-1:0];
        res_o.pixel_color = color_q;
      end
    end
  end

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    err_d   = err_q;
    steps_d = steps_q;
    color_d = color_q;
    busy_d  = busy_q;
    if (fire_i) begin
      if (item_i.opcode == OP_START) begin
        cur_x_d = x1;
        cur_y_d = y1;
        tgt_x_d = x2;
        tgt_y_d = y2;
        dx_d    = dx_new;
        dy_d    = dy_new;
        neg_x_d = !(x1 < x2);
        neg_y_d = !(y1 < y2);
        err_d   = signed'(ErrW'(dx_new)) - signed'(ErrW'(dy_new));
        steps_d = '0;
        color_d = item_i.line_color;
        busy_d  = 1'b1;
      end else if (busy_q) begin
        if (done) begin
          busy_d = 1'b0;
        end else begin
          err_d   = err_e[ErrW-1:0];
          steps_d = steps_q + LIMIT_W'(1);
          if (move_x) begin
            cur_x_d = neg_x_q ? cur_x_q - CoordBits'(1) : cur_x_q + CoordBits'(1);
          end
          if (move_y) begin
            cur_y_d = neg_y_q ? cur_y_q - CoordBits'(1) : cur_y_q + CoordBits'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      err_q   <= '0;
      steps_q <= '0;
      color_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
      err_q   <= err_d;
      steps_q <= steps_d;
      color_q <= color_d;
      busy_q  <= busy_d;
    end
  end

  assign status_o.busy = busy_q;

endmodule

`default_nettype wire
